// ----- hw/rtl/dinucleotide_stacking_window_max_unit_defines.svh -----
// Assertion macros shared by the stacking window max RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef DINUCLEOTIDE_STACKING_WINDOW_MAX_UNIT_DEFINES_SVH
`define DINUCLEOTIDE_STACKING_WINDOW_MAX_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define DSWM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dswm check failed");

// Next-cycle implication, disabled in reset.
`define DSWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dswm check failed");

`endif

// ----- hw/rtl/dswm_pkg.sv -----
// Shared constants, types and the stacking energy table for the window max unit.
// No dependencies; used by every other file of the block but the defines header.
package dswm_pkg;

  localparam int unsigned MAX_WINDOW_DEFAULT = 64;
  localparam int unsigned QUEUE_DEPTH        = 2;
  localparam int unsigned WINDOW_LEN_W       = 7;
  localparam int unsigned WINDOW_LEN_RESET   = 2;
  localparam int unsigned BASE_W             = 8;
  localparam int unsigned ENERGY_W           = 11;
  localparam int unsigned ENERGY_MAX         = 1459;
  localparam int unsigned BEST_W             = 18;
  localparam int unsigned MEAN_W             = 12;

  typedef logic [BASE_W-1:0]   base_t;
  typedef logic [ENERGY_W-1:0] energy_t;
  typedef logic [1:0]          base_idx_t;

  localparam base_t CHAR_A = 8'd65;
  localparam base_t CHAR_C = 8'd67;
  localparam base_t CHAR_G = 8'd71;
  localparam base_t CHAR_T = 8'd84;

  localparam base_idx_t IDX_A = 2'd0;
  localparam base_idx_t IDX_C = 2'd1;
  localparam base_idx_t IDX_G = 2'd2;
  localparam base_idx_t IDX_T = 2'd3;

  // Energy magnitudes in hundredths of kcal/mol; row is first base, column second.
  localparam energy_t PAIR_MAG [4][4] = '{
    '{11'd537, 11'd1051, 11'd678,  11'd657},
    '{11'd657, 11'd826,  11'd969,  11'd678},
    '{11'd981, 11'd1459, 11'd826,  11'd1051},
    '{11'd382, 11'd981,  11'd657,  11'd537}
  };

  typedef struct packed {
    logic      ok;
    base_idx_t idx;
  } base_code_t;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_DIVIDE,
    BACK_DONE
  } back_state_t;

  function automatic base_code_t base_code(input base_t c);
    base_code_t r;
    r.ok  = 1'b1;
    r.idx = IDX_A;
    unique case (c)
      CHAR_A:  r.idx = IDX_A;
      CHAR_C:  r.idx = IDX_C;
      CHAR_G:  r.idx = IDX_G;
      CHAR_T:  r.idx = IDX_T;
      default: r.ok  = 1'b0;
    endcase
    return r;
  endfunction

  // Pairs with any character other than uppercase ACGT count zero.
  function automatic energy_t pair_energy(input base_t a, input base_t b);
    base_code_t ca;
    base_code_t cb;
    ca = base_code(a);
    cb = base_code(b);
    if (ca.ok && cb.ok) begin
      return PAIR_MAG[ca.idx][cb.idx];
    end
    return '0;
  endfunction

endpackage

// ----- hw/rtl/dswm_if.sv -----
// Valid/ready channel interfaces for samples, results and window configuration.
// Depends on dswm_pkg for field widths.
interface dswm_in_if;
  logic                           valid;
  logic                           ready;
  logic [dswm_pkg::BASE_W-1:0]    base_char;
  logic                           region_end;
  modport source (output valid, base_char, region_end, input ready);
  modport sink   (input valid, base_char, region_end, output ready);
endinterface

interface dswm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dswm_pkg::MEAN_W-1:0]  mean_energy_centi;
  logic signed [dswm_pkg::BEST_W-1:0]  best_sum_centi;
  logic                                too_short;
  modport source (output valid, mean_energy_centi, best_sum_centi, too_short, input ready);
  modport sink   (input valid, mean_energy_centi, best_sum_centi, too_short, output ready);
endinterface

interface dswm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [dswm_pkg::WINDOW_LEN_W-1:0]   window_len;
  modport source (output valid, window_len, input ready);
  modport sink   (input valid, window_len, output ready);
endinterface

// ----- hw/rtl/dswm_queue.sv -----
// Short FIFO that decouples the streaming front end from the divider back end.
// Depends on dswm_pkg for the default depth.
module dswm_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = dswm_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/dswm_front.sv -----
// Front end: one base per cycle unless the queue is full; pair-energy ring, window
// sum, best-sum tracking, one queued entry per region. Depends on dswm_pkg, dswm_if.
`include "dinucleotide_stacking_window_max_unit_defines.svh"

module dswm_front #(
  parameter  int unsigned MAX_WINDOW = dswm_pkg::MAX_WINDOW_DEFAULT,
  localparam int unsigned PAIRS_W    = $clog2(MAX_WINDOW),
  localparam int unsigned ENTRY_W    = dswm_pkg::BEST_W + 1 + PAIRS_W
) (
  input  logic               clk,
  input  logic               rst,
  dswm_cfg_if.sink           cfg,
  dswm_in_if.sink            samples,
  output logic               push_valid,
  input  logic               push_ready,
  output logic [ENTRY_W-1:0] push_data
);

  localparam int unsigned WIN_W      = $clog2(MAX_WINDOW + 1);
  localparam int unsigned RING_DEPTH = MAX_WINDOW - 1;
  localparam int unsigned AW         = (MAX_WINDOW > 2) ? $clog2(MAX_WINDOW - 1) : 1;
  localparam int unsigned PAW        = ((AW > PAIRS_W) ? AW : PAIRS_W) + 1;
  localparam int unsigned CW         = (WIN_W > dswm_pkg::WINDOW_LEN_W) ?
                                       WIN_W : dswm_pkg::WINDOW_LEN_W;
  localparam int unsigned SUM_RAW_W  =
    $clog2(dswm_pkg::ENERGY_MAX * (MAX_WINDOW - 1) + 1) + 1;
  localparam int unsigned SW         = (SUM_RAW_W > dswm_pkg::BEST_W) ?
                                       SUM_RAW_W : dswm_pkg::BEST_W;
  localparam logic signed [SW-1:0] BEST_INIT =
    {{(SW - dswm_pkg::BEST_W + 1){1'b1}}, {(dswm_pkg::BEST_W - 1){1'b0}}};

  // Configuration, held as the clamped window and its pair count.
  logic [WIN_W-1:0]   w_eff;
  logic [PAIRS_W-1:0] pairs;
  logic [CW-1:0]      wl_ext;
  logic [WIN_W-1:0]   w_eff_next;
  logic               cfg_acc;

  // Region state.
  dswm_pkg::base_t     previous_base;
  logic signed [SW-1:0] window_sum;
  logic signed [SW-1:0] best_sum;
  logic [WIN_W-1:0]    bases_seen;
  logic [AW-1:0]       ring_pointer;

  // Pair energy ring.
  dswm_pkg::energy_t   ring [RING_DEPTH];
  dswm_pkg::energy_t   ring_q;
  logic [AW-1:0]       raddr;
  logic                we;

  logic                 acc;
  logic                 clear_region;
  logic                 have_prev;
  logic                 window_full;
  dswm_pkg::energy_t    e;
  dswm_pkg::energy_t    ring_add;
  logic signed [SW-1:0] sum_next;
  logic signed [SW-1:0] best_next;
  logic [WIN_W-1:0]     seen_next;
  logic [PAW-1:0]       p_inc;
  logic [AW-1:0]        p_adv;
  logic [AW-1:0]        p_next;
  logic                 too_short;

  assign cfg.ready     = 1'b1;
  assign cfg_acc       = cfg.valid && cfg.ready;
  assign samples.ready = push_ready;
  assign acc           = samples.valid && samples.ready;
  assign clear_region  = cfg_acc || (acc && samples.region_end);

  assign wl_ext = CW'(cfg.window_len);

  always_comb begin
    if (wl_ext < CW'(2)) begin
      w_eff_next = WIN_W'(2);
    end else if (wl_ext > CW'(MAX_WINDOW)) begin
      w_eff_next = WIN_W'(MAX_WINDOW);
    end else begin
      w_eff_next = WIN_W'(wl_ext);
    end
  end

  always_comb begin
    have_prev   = (bases_seen != '0);
    window_full = (bases_seen >= w_eff);
    e           = dswm_pkg::pair_energy(previous_base, samples.base_char);
    ring_add    = window_full ? ring_q : '0;
    // Add back the pair leaving the window, subtract the magnitude entering it.
    sum_next    = have_prev ?
                  (window_sum + $signed(SW'(ring_add)) - $signed(SW'(e))) : window_sum;
    seen_next   = (bases_seen < w_eff) ? bases_seen + WIN_W'(1) : bases_seen;
    best_next   = ((seen_next >= w_eff) && (sum_next > best_sum)) ? sum_next : best_sum;
    too_short   = (seen_next < w_eff);
    p_inc       = PAW'(ring_pointer) + PAW'(1);
    p_adv       = (p_inc >= PAW'(pairs)) ? '0 : AW'(p_inc);
    p_next      = have_prev ? p_adv : ring_pointer;
    we          = acc && have_prev;
    if (clear_region) begin
      raddr = '0;
    end else if (acc) begin
      raddr = p_next;
    end else begin
      raddr = ring_pointer;
    end
  end

  assign push_valid = acc && samples.region_end;
  assign push_data  = {best_next[dswm_pkg::BEST_W-1:0], too_short, pairs};

  // Read-first ring with a bypass when the next slot is the one being written.
  always_ff @(posedge clk) begin
    if (we) begin
      ring[ring_pointer] <= e;
    end
    if (we && (ring_pointer == raddr)) begin
      ring_q <= e;
    end else begin
      ring_q <= ring[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff <= WIN_W'(dswm_pkg::WINDOW_LEN_RESET);
      pairs <= PAIRS_W'(dswm_pkg::WINDOW_LEN_RESET - 1);
    end else if (cfg_acc) begin
      w_eff <= w_eff_next;
      pairs <= PAIRS_W'(w_eff_next - WIN_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_region) begin
      previous_base <= '0;
      window_sum    <= '0;
      best_sum      <= BEST_INIT;
      bases_seen    <= '0;
      ring_pointer  <= '0;
    end else if (acc) begin
      previous_base <= samples.base_char;
      window_sum    <= sum_next;
      best_sum      <= best_next;
      bases_seen    <= seen_next;
      ring_pointer  <= p_next;
    end
  end

  `DSWM_ASSERT_NOW(a_ptr_in_range, clk, rst, 1'b1, PAW'(ring_pointer) < PAW'(pairs))
  `DSWM_ASSERT_NOW(a_sum_nonpositive, clk, rst, 1'b1, !(window_sum > 0))
  `DSWM_ASSERT_NEXT(a_region_cleared, clk, rst, acc && samples.region_end,
                    bases_seen == '0 && window_sum == '0)

endmodule

// ----- hw/rtl/dswm_back.sv -----
// Back end: restoring divider for the region mean and the result output register.
// Depends on dswm_pkg, dswm_if.
`include "dinucleotide_stacking_window_max_unit_defines.svh"

module dswm_back #(
  parameter  int unsigned MAX_WINDOW = dswm_pkg::MAX_WINDOW_DEFAULT,
  localparam int unsigned PAIRS_W    = $clog2(MAX_WINDOW),
  localparam int unsigned ENTRY_W    = dswm_pkg::BEST_W + 1 + PAIRS_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  logic [ENTRY_W-1:0] pop_data,
  dswm_out_if.source         results
);

  localparam int unsigned BW     = dswm_pkg::BEST_W;
  localparam int unsigned STEP_W = $clog2(BW);

  dswm_pkg::back_state_t state;
  dswm_pkg::back_state_t state_next;

  logic signed [BW-1:0] best_in;
  logic                 short_in;
  logic [PAIRS_W-1:0]   div_in;

  logic signed [BW-1:0] best_hold;
  logic                 short_hold;
  logic [PAIRS_W-1:0]   divisor;
  logic [BW-1:0]        quo;
  logic [PAIRS_W-1:0]   rem;
  logic [STEP_W-1:0]    step;

  logic [PAIRS_W:0]     shifted;
  logic                 fits;
  logic [BW-1:0]        neg_quo;
  logic                 take;
  logic                 div_en;
  logic                 load_out;
  logic                 last_step;

  assign best_in  = $signed(pop_data[ENTRY_W-1 -: BW]);
  assign short_in = pop_data[PAIRS_W];
  assign div_in   = pop_data[PAIRS_W-1:0];

  assign take      = pop_valid && pop_ready;
  assign last_step = (step == STEP_W'(BW - 1));
  assign shifted   = {rem, quo[BW-1]};
  assign fits      = (shifted >= {1'b0, divisor});
  assign neg_quo   = '0 - quo;

  always_comb begin
    state_next = state;
    unique case (state)
      dswm_pkg::BACK_IDLE: begin
        if (pop_valid) begin
          state_next = short_in ? dswm_pkg::BACK_DONE : dswm_pkg::BACK_DIVIDE;
        end
      end
      dswm_pkg::BACK_DIVIDE: begin
        if (last_step) begin
          state_next = dswm_pkg::BACK_DONE;
        end
      end
      dswm_pkg::BACK_DONE: begin
        if (load_out) begin
          state_next = dswm_pkg::BACK_IDLE;
        end
      end
      default: state_next = dswm_pkg::BACK_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = 1'b0;
    div_en    = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      dswm_pkg::BACK_IDLE:   pop_ready = 1'b1;
      dswm_pkg::BACK_DIVIDE: div_en    = 1'b1;
      dswm_pkg::BACK_DONE:   load_out  = !results.valid || results.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dswm_pkg::BACK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Divide the magnitude of the best sum, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (take) begin
      best_hold  <= best_in;
      short_hold <= short_in;
      divisor    <= div_in;
      quo        <= BW'(-best_in);
      rem        <= '0;
      step       <= '0;
    end else if (div_en) begin
      if (fits) begin
        rem <= PAIRS_W'(shifted - {1'b0, divisor});
      end else begin
        rem <= shifted[PAIRS_W-1:0];
      end
      quo  <= {quo[BW-2:0], fits};
      step <= step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (load_out) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      results.too_short <= short_hold;
      if (short_hold) begin
        results.mean_energy_centi <= '0;
        results.best_sum_centi    <= '0;
      end else begin
        results.mean_energy_centi <= $signed(neg_quo[dswm_pkg::MEAN_W-1:0]);
        results.best_sum_centi    <= best_hold;
      end
    end
  end

  `DSWM_ASSERT_NOW(a_step_bound, clk, rst, state == dswm_pkg::BACK_DIVIDE,
                   step < STEP_W'(BW))
  `DSWM_ASSERT_NOW(a_short_zero, clk, rst, results.valid && results.too_short,
                   results.mean_energy_centi == '0 && results.best_sum_centi == '0)
  `DSWM_ASSERT_NOW(a_mean_nonpositive, clk, rst, results.valid,
                   !(results.mean_energy_centi > 0) && !(results.best_sum_centi > 0))

endmodule

// ----- hw/rtl/dinucleotide_stacking_window_max_unit.sv -----
// Top level of the dinucleotide stacking window max unit.
// Depends on dswm_pkg, dswm_if, dswm_front, dswm_queue and dswm_back.
// The front end takes one base per clock: pair energy lookup, the ring of pair
// energies (a 63-entry memory at the default MAX_WINDOW, no clearing pass after
// reset) and the running window sum all update together on each accepted base. On
// the base that ends a region the front end queues one entry into a two-entry
// FIFO; the back end takes an entry only while idle, runs a restoring divider over
// the 18 quotient bits, then loads the result register and goes back to idle; a
// too-short region skips the divider. Input stalls only when regions end faster
// than the back end drains them and the FIFO fills, or when results are not taken.
module dinucleotide_stacking_window_max_unit #(
  parameter int unsigned MAX_WINDOW = dswm_pkg::MAX_WINDOW_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  dswm_cfg_if.sink    cfg,
  dswm_in_if.sink     samples,
  dswm_out_if.source  results
);

  localparam int unsigned PAIRS_W = $clog2(MAX_WINDOW);
  localparam int unsigned ENTRY_W = dswm_pkg::BEST_W + 1 + PAIRS_W;

  logic               push_valid;
  logic               push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               pop_valid;
  logic               pop_ready;
  logic [ENTRY_W-1:0] pop_data;

  dswm_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .samples    (samples),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  dswm_queue #(
    .DATA_W (ENTRY_W),
    .DEPTH  (dswm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  dswm_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .results   (results)
  );

endmodule
